@@ rtl/differential_drive_odometry_defines.svh @@
// Assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define ODO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry check failed");

// next-cycle implication
`define ODO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

`else

`define ODO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ODO_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/odo_pkg.sv @@
package odo_pkg;

	localparam int POS_W        = 32;
	localparam int ANG_W        = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_W       = 16;
	localparam int Z_W          = 32;
	localparam int HI_SHIFT     = 32;
	localparam int XY_W         = POS_W + 2;
	localparam int MUL_B_W      = 32;
	localparam int PROD_W       = XY_W + MUL_B_W + 1;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_N       = 24;
	localparam int ATAN_IDX_W   = $clog2(ATAN_N);
	localparam int REG_W        = 31;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(2);

	localparam logic [REG_W-1:0]   UNITY_Q16 = REG_W'(65536);
	localparam logic [MUL_B_W-1:0] INV_GAIN  = 32'h9B74EDA8;

	// arctangent of 2^-i, 2^32 units per turn
	localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic load;
		logic step;
	} cordic_ctrl_t;

	typedef struct packed {
		logic last;
	} cordic_stat_t;

endpackage

@@ rtl/odo_in_if.sv @@
interface odo_in_if import odo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] left_position;
	logic signed [POS_W-1:0] right_position;

	modport source (output valid, output left_position, output right_position, input ready);
	modport sink (input valid, input left_position, input right_position, output ready);
endinterface

@@ rtl/odo_out_if.sv @@
interface odo_out_if import odo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pose_x;
	logic signed [POS_W-1:0] pose_y;
	logic signed [ANG_W-1:0] pose_heading;

	modport source (output valid, output pose_x, output pose_y, output pose_heading,
		input ready);
	modport sink (input valid, input pose_x, input pose_y, input pose_heading,
		output ready);
endinterface

@@ rtl/odo_mul.sv @@
module odo_mul import odo_pkg::*; (
	input  logic                     clk,
	input  logic signed [XY_W-1:0]   a,
	input  logic        [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// b is unsigned: widen by a zero sign bit
	always_ff @(posedge clk) begin
		prod_q <= a * $signed({1'b0, b});
	end

	assign prod = prod_q;

endmodule

@@ rtl/odo_cordic.sv @@
module odo_cordic import odo_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cordic_ctrl_t            ctrl,
	input  logic signed [XY_W-1:0]  x0,
	input  logic        [ANG_W-1:0] heading,
	output logic signed [XY_W-1:0]  x,
	output logic signed [XY_W-1:0]  y,
	output cordic_stat_t            stat
);

	logic signed [XY_W-1:0] x_q, y_q, xs, ys;
	logic [Z_W-1:0]         z_q, z0, atan;
	logic [STEP_W-1:0]      cnt_q;
	logic                   flip;

	always_comb begin
		xs   = x_q >>> cnt_q;
		ys   = y_q >>> cnt_q;
		atan = ATAN_TURNS[ATAN_IDX_W'(cnt_q)];
		z0   = {heading, {(Z_W-ANG_W){1'b0}}};
		// left half plane: negate the vector, turn the angle by pi
		flip = z0[Z_W-1] ^ z0[Z_W-2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= flip ? -x0 : x0;
			y_q <= '0;
			z_q <= {z0[Z_W-1] ^ flip, z0[Z_W-2:0]};
		end else if (ctrl.step) begin
			if (z_q[Z_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan;
			end
		end
	end

	assign x         = x_q;
	assign y         = y_q;
	assign stat.last = (cnt_q == STEP_W'(CORDIC_STEPS - 1));

endmodule

@@ rtl/differential_drive_odometry.sv @@
// Channel   Dir  Payload                              Transfer when
// pos_in    in   left_position, right_position        valid && ready
// pose_out  out  pose_x, pose_y, pose_heading         valid && ready
// cfg       in   cfg_index, cfg_data                  cfg_we
//
// One item keeps the sequencer busy after its transfer: setup states S_MUL_L to S_INIT on the
// shared multiplier, one CORDIC micro-rotation per cycle in S_ROT, one commit in S_ACC.
// The next transfer can come in the cycle after the commit.
// pos_in.ready is high only while the sequencer is idle.
// The pose register holds the last result; the next item is taken and worked on while it
// waits, and the commit stalls until pose_out is free.
// arst_n clears the pose, previous positions and registers to their reset values.
`include "differential_drive_odometry_defines.svh"

module differential_drive_odometry import odo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	odo_in_if.sink               pos_in,
	odo_out_if.source            pose_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL_L = 4'd1;
	localparam logic [3:0] S_MUL_R = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_DIFF  = 4'd4;
	localparam logic [3:0] S_MUL_T = 4'd5;
	localparam logic [3:0] S_MUL_X = 4'd6;
	localparam logic [3:0] S_INIT  = 4'd7;
	localparam logic [3:0] S_ROT   = 4'd8;
	localparam logic [3:0] S_ACC   = 4'd9;

	logic [3:0]               state_q;
	logic                     scale_q;
	logic [REG_W-1:0]         radius_q, gain_q;
	logic [POS_W-1:0]         last_left_q, last_right_q, acc_x_q, acc_y_q;
	logic [ANG_W-1:0]         heading_q, dth_q;
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  dl_q, dr_q, dist_q;
	logic signed [POS_W:0]    diff_q, sum;
	logic signed [XY_W-1:0]   mul_a, cor_x, cor_y, x0;
	logic [MUL_B_W-1:0]       mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [POS_W-1:0]         scaled;
	logic                     accept, commit;
	cordic_ctrl_t             cctrl;
	cordic_stat_t             cstat;

	assign accept = pos_in.valid && pos_in.ready;
	assign commit = (state_q == S_ACC) && (!out_valid_q || pose_out.ready);

	always_comb begin
		sum    = {dl_q[POS_W-1], dl_q} + {dr_q[POS_W-1], dr_q};
		scaled = prod[FRAC_W+POS_W-1:FRAC_W];
		x0     = prod[HI_SHIFT+XY_W-1:HI_SHIFT];

		mul_a = {{(XY_W-POS_W){dl_q[POS_W-1]}}, dl_q};
		mul_b = {1'b0, radius_q};
		case (state_q)
			S_MUL_R: begin
				mul_a = {{(XY_W-POS_W){dr_q[POS_W-1]}}, dr_q};
			end
			S_MUL_T: begin
				mul_a = {{(XY_W-POS_W-1){diff_q[POS_W]}}, diff_q};
				mul_b = {1'b0, gain_q};
			end
			S_MUL_X: begin
				mul_a = {{(XY_W-POS_W){dist_q[POS_W-1]}}, dist_q};
				mul_b = INV_GAIN;
			end
			default: ;
		endcase

		cctrl.load = (state_q == S_INIT);
		cctrl.step = (state_q == S_ROT);
	end

	odo_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	odo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cctrl),
		.x0      (x0),
		.heading (heading_q),
		.x       (cor_x),
		.y       (cor_y),
		.stat    (cstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scale_q      <= 1'b0;
			radius_q     <= UNITY_Q16;
			gain_q       <= UNITY_Q16;
			last_left_q  <= '0;
			last_right_q <= '0;
			heading_q    <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE:  scale_q  <= cfg_data[0];
					REG_RADIUS: radius_q <= cfg_data;
					REG_GAIN:   gain_q   <= cfg_data;
					default: ;
				endcase
			end

			// drop the pose after its transfer unless a new one replaces it
			if (pose_out.ready && !commit) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_left_q  <= pos_in.left_position;
						last_right_q <= pos_in.right_position;
						state_q      <= S_MUL_L;
					end
				end
				S_MUL_L: state_q <= S_MUL_R;
				S_MUL_R: state_q <= S_SUM;
				S_SUM:   state_q <= S_DIFF;
				S_DIFF:  state_q <= S_MUL_T;
				S_MUL_T: state_q <= S_MUL_X;
				S_MUL_X: state_q <= S_INIT;
				S_INIT:  state_q <= S_ROT;
				S_ROT: begin
					if (cstat.last) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					// hold until the pose register is free
					if (commit) begin
						acc_x_q     <= acc_x_q + cor_x[POS_W-1:0];
						acc_y_q     <= acc_y_q + cor_y[POS_W-1:0];
						heading_q   <= heading_q + dth_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dl_q <= pos_in.left_position - last_left_q;
					dr_q <= pos_in.right_position - last_right_q;
				end
			end
			S_MUL_R: begin
				if (scale_q) begin
					dl_q <= scaled;
				end
			end
			S_SUM: begin
				if (scale_q) begin
					dr_q <= scaled;
				end
			end
			S_DIFF: begin
				dist_q <= sum[POS_W:1];
				diff_q <= {dr_q[POS_W-1], dr_q} - {dl_q[POS_W-1], dl_q};
			end
			S_MUL_X: begin
				dth_q <= prod[HI_SHIFT+ANG_W-1:HI_SHIFT];
			end
			default: ;
		endcase
	end

	assign pos_in.ready          = (state_q == S_IDLE);
	assign pose_out.valid        = out_valid_q;
	assign pose_out.pose_x       = acc_x_q;
	assign pose_out.pose_y       = acc_y_q;
	assign pose_out.pose_heading = heading_q;

	`ODO_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == S_MUL_L)
	`ODO_ASSERT_NEXT(a_rot_continues, clk, arst_n, state_q == S_ROT && !cstat.last, state_q == S_ROT)
	`ODO_ASSERT_NEXT(a_commit_shows, clk, arst_n, commit, out_valid_q && state_q == S_IDLE)
	`ODO_ASSERT_SAME(a_init_in_order, clk, arst_n, state_q == S_INIT, $past(state_q) == S_MUL_X)

endmodule

@@ bench/odo_pose_checker.sv @@
module odo_pose_checker import odo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	odo_in_if                    pos_in,
	odo_out_if                   pose_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   poses_checked,
	output int                   poses_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint RECIP_CORDIC_GAIN = 64'h0000_0000_9B74_EDA8;
	localparam int     MAX_PRINTED       = 40;

	// arctangent of 2^-i, one full turn is 2^32
	localparam logic [31:0] ROT_ANGLE [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [ANG_W-1:0] heading;
	} pose_t;

	logic             scale_on;
	logic [REG_W-1:0] radius_q16;
	logic [REG_W-1:0] gain_q16;
	logic [POS_W-1:0] prev_left;
	logic [POS_W-1:0] prev_right;
	logic [POS_W-1:0] acc_x;
	logic [POS_W-1:0] acc_y;
	logic [ANG_W-1:0] hdg;
	pose_t            expected_poses [$];

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] pose %0d: %s", $time, poses_checked, msg);
	endtask

	// Advance the tracked pose by one pair of wheel positions.
	function automatic pose_t advance_pose(input logic [POS_W-1:0] pl,
		input logic [POS_W-1:0] pr);
		longint      dl, dr, travel, turn, cx, cy, xs, ys, sh;
		logic [31:0] z;
		pose_t       p;
		dl = longint'($signed(pl - prev_left));
		dr = longint'($signed(pr - prev_right));
		if (scale_on) begin
			sh = (dl * longint'(radius_q16)) >>> FRAC_W;
			dl = longint'($signed(sh[POS_W-1:0]));
			sh = (dr * longint'(radius_q16)) >>> FRAC_W;
			dr = longint'($signed(sh[POS_W-1:0]));
		end
		prev_left  = pl;
		prev_right = pr;

		travel = (dl + dr) >>> 1;
		turn   = ((dr - dl) * longint'(gain_q16)) >>> 32;

		// rotate along the old heading
		z  = {hdg, {(32 - ANG_W){1'b0}}};
		cx = (travel * RECIP_CORDIC_GAIN) >>> 32;
		cy = 0;
		if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
			cx = -cx;
			z  = z + 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (!z[31]) begin
				cx = cx - ys;
				cy = cy + xs;
				z  = z - ROT_ANGLE[i];
			end else begin
				cx = cx + ys;
				cy = cy - xs;
				z  = z + ROT_ANGLE[i];
			end
		end

		hdg   = hdg + turn[ANG_W-1:0];
		acc_x = acc_x + cx[POS_W-1:0];
		acc_y = acc_y + cy[POS_W-1:0];
		p.x       = acc_x;
		p.y       = acc_y;
		p.heading = hdg;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			scale_on   = 1'b0;
			radius_q16 = REG_W'(65536);
			gain_q16   = REG_W'(65536);
			prev_left  = '0;
			prev_right = '0;
			acc_x      = '0;
			acc_y      = '0;
			hdg        = '0;
			expected_poses.delete();
			poses_due  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE:  scale_on = cfg_data[0];
					REG_RADIUS: radius_q16 = cfg_data;
					REG_GAIN:   gain_q16 = cfg_data;
					default: ;
				endcase
			end
			if (pose_out.valid && pose_out.ready) begin
				if (expected_poses.size() == 0) begin
					report($sformatf("unexpected transfer x=%h y=%h heading=%h",
						pose_out.pose_x, pose_out.pose_y, pose_out.pose_heading));
				end else begin
					want = expected_poses.pop_front();
					if (pose_out.pose_x !== want.x)
						report($sformatf("pose_x got %h, expected %h", pose_out.pose_x, want.x));
					if (pose_out.pose_y !== want.y)
						report($sformatf("pose_y got %h, expected %h", pose_out.pose_y, want.y));
					if (pose_out.pose_heading !== want.heading)
						report($sformatf("pose_heading got %h, expected %h",
							pose_out.pose_heading, want.heading));
					poses_checked++;
				end
			end
			if (pos_in.valid && pos_in.ready)
				expected_poses.push_back(advance_pose(pos_in.left_position,
					pos_in.right_position));
			poses_due = expected_poses.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top import odo_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 400000;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	odo_in_if  pos_if ();
	odo_out_if pose_if ();

	int               mismatches;
	int               poses_checked;
	int               poses_due;
	int               samples_sent;
	int               reg_writes;
	int               settings_run;
	int               cycles;
	bit               idling = 1'b1;
	logic [POS_W-1:0] last_l;
	logic [POS_W-1:0] last_r;

	always #6ns clk = ~clk;

	differential_drive_odometry i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_in    (pos_if),
		.pose_out  (pose_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	odo_pose_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pos_in        (pos_if),
		.pose_out      (pose_if),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.poses_checked (poses_checked),
		.poses_due     (poses_due)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("differential_drive_odometry test failed");
			$finish;
		end
	end

	// pose consumer: stall in random bursts while idling is on
	initial begin
		pose_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				pose_if.ready <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				pose_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [POS_W-1:0] l, input logic [POS_W-1:0] r);
		if (idling && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			pos_if.valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
		@(negedge clk);
		pos_if.valid          <= 1'b1;
		pos_if.left_position  <= l;
		pos_if.right_position <= r;
		do @(posedge clk); while (!pos_if.ready);
		last_l = l;
		last_r = r;
		samples_sent++;
	endtask

	function automatic logic [POS_W-1:0] extreme_position(input logic [POS_W-1:0] base);
		case ($urandom_range(0, 5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			4:       return base + 32'h7FFF_FFFF;
			default: return base + 32'h8000_0000;
		endcase
	endfunction

	// Mostly smooth wheel motion, some arbitrary jumps and wrap-range steps.
	task automatic send_random(input int count);
		logic [POS_W-1:0] l, r;
		int               kind;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				l = last_l + POS_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
				r = last_r + POS_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
				// sharp turn now and then
				if (kind < 15)
					r = r + ($urandom & 32'h0FFF_FFFF);
			end else if (kind < 85) begin
				l = $urandom;
				r = $urandom;
			end else begin
				l = extreme_position(last_l);
				r = extreme_position(last_r);
			end
			send_item(l, r);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_writes++;
	endtask

	// Hold the sender until every pose is out and the block has gone quiet.
	task automatic settle();
		@(negedge clk);
		pos_if.valid <= 1'b0;
		while (poses_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input logic scale, input logic [REG_W-1:0] radius,
		input logic [REG_W-1:0] gain);
		settle();
		write_reg(REG_SCALE, REG_W'(scale));
		write_reg(REG_RADIUS, radius);
		write_reg(REG_GAIN, gain);
		settings_run++;
	endtask

	initial begin
		pos_if.valid          = 1'b0;
		pos_if.left_position  = '0;
		pos_if.right_position = '0;
		cfg_we                = 1'b0;
		cfg_index             = REG_SCALE;
		cfg_data              = '0;
		last_l                = '0;
		last_r                = '0;
		settings_run          = 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: unit radius off, unit gain
		send_item(32'h0000_0000, 32'h0000_0000);
		send_item(32'h0001_0000, 32'h0001_0000);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h0000_0000, 32'h0000_0000);
		send_item(32'h8000_0000, 32'h0000_0000);
		send_item(32'h0000_0000, 32'h7FFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'h0000_0001);
		send_item(32'h4000_0000, 32'hC000_0000);
		// quarter turns walk the heading through every quadrant
		repeat (4) send_item(last_l + 32'h0001_0000, last_r + 32'h4001_0000);
		send_item(32'h7FFF_FFFF, 32'h8000_0000);
		send_random(200);

		apply_setting(1'b1, REG_W'(65536), REG_W'(65536));
		send_random(200);

		// zero radius kills all travel; the spare index must change nothing
		apply_setting(1'b1, REG_W'(0), REG_W'(32'h7FFF_FFFF));
		write_reg(REG_SPARE, REG_W'($urandom));
		send_random(150);

		apply_setting(1'b1, REG_W'(32'h7FFF_FFFF), REG_W'(0));
		send_random(150);

		apply_setting(1'b0, REG_W'($urandom), REG_W'(32'h0040_0000));
		send_random(200);

		repeat (2) begin
			apply_setting(1'($urandom), REG_W'($urandom_range(0, 32'h0004_0000)),
				REG_W'($urandom));
			send_random(200);
		end

		// closing stretch runs back to back on both sides
		apply_setting(1'b1, REG_W'(32'h0001_8000), REG_W'(32'h0001_0000));
		idling = 1'b0;
		send_random(300);
		settle();

		$display("%0d wheel samples over %0d register settings (%0d writes), %0d poses compared",
			samples_sent, settings_run, reg_writes, poses_checked);
		if (mismatches == 0) begin
			$display("differential_drive_odometry test passed");
		end else begin
			$display("differential_drive_odometry test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/odo_pkg.sv
rtl/odo_in_if.sv
rtl/odo_out_if.sv
rtl/odo_mul.sv
rtl/odo_cordic.sv
rtl/differential_drive_odometry.sv
bench/odo_pose_checker.sv
bench/tb_top.sv
